### design/mhpq_pkg.sv
// Shared types and codes for the max-heap priority queue.
`default_nettype none

package mhpq_pkg;

    localparam int DEFAULT_CAPACITY = 128;
    localparam int VALUE_W          = 32;
    localparam int TOTAL_W          = 8;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        req_kind_t                  req_type;
        logic signed [VALUE_W-1:0]  value;
    } req_t;

    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  removed_value;
        logic [TOTAL_W-1:0]         entry_total;
        logic signed [VALUE_W-1:0]  top_value;
    } rsp_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic                       shift_in;
        logic                       shift_out;
        logic signed [VALUE_W-1:0]  value;
    } cell_ctl_t;

endpackage

`default_nettype wire

### design/mhpq_cell.sv
// One cell of the sorted chain: holds one entry and trades with its neighbors.
`default_nettype none

module mhpq_cell (
    input  wire logic                                 clk,
    input  wire mhpq_pkg::cell_ctl_t                  ctl,
    input  wire logic                                 vacant,
    input  wire logic signed [mhpq_pkg::VALUE_W-1:0]  prev_value,
    input  wire logic                                 prev_greater,
    input  wire logic signed [mhpq_pkg::VALUE_W-1:0]  next_value,
    output logic signed [mhpq_pkg::VALUE_W-1:0]       value,
    output logic                                      greater
);
    import mhpq_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    // An empty cell ranks below any value, so the new value lands in the
    // first cell it beats and everything behind it moves one place down.
    assign greater = vacant || (ctl.value > value_reg);
    assign value   = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.shift_in)
        begin
            if (greater)
            begin
                value_next = prev_greater ? prev_value : ctl.value;
            end
        end
        else if (ctl.shift_out)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

### design/max_heap_priority_queue.sv
// Top level of the max-heap priority queue: controller and chain of cells.
//
// Requests enter on req (req_valid / req_stall): an insert of a signed
// 32-bit value or a remove of the largest entry. Every request produces
// exactly one response on rsp (rsp_valid / rsp_stall) with the status, the
// removed value, the entry count and the largest entry after the operation.
// Entries are held in a chain of CAPACITY cells kept in descending order;
// an insert places the value with every cell comparing in parallel, and a
// remove shifts the whole chain up by one cell.
// A response is registered and shows in the cycle after its request transfer,
// and the block takes one request per cycle while responses are taken.
// The response register is the only buffer: while it holds an untaken
// response and rsp_stall is high, req_stall is high as well.
// Reset empties the queue and drops any pending response; cell contents
// are not cleared, since only occupied cells are ever read.
// An insert on a full queue or a remove on an empty one is flagged in the
// status and leaves the contents unchanged.
`default_nettype none

module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire mhpq_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output mhpq_pkg::rsp_t      rsp
);
    import mhpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    rsp_t                       rsp_reg;
    rsp_t                       rsp_next;

    logic                       accept;
    logic                       is_full;
    logic                       is_empty;
    logic                       insert_ok;
    logic                       remove_ok;
    cell_ctl_t                  ctl;

    logic signed [VALUE_W-1:0]  cell_value   [CAPACITY];
    logic                       cell_greater [CAPACITY];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign insert_ok = accept && (req.req_type == REQ_INSERT) && !is_full;
    assign remove_ok = accept && (req.req_type == REQ_REMOVE) && !is_empty;

    assign ctl.shift_in  = insert_ok;
    assign ctl.shift_out = remove_ok;
    assign ctl.value     = req.value;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] prev_value;
        logic                      prev_greater;
        logic signed [VALUE_W-1:0] next_value;
        logic                      vacant;

        assign vacant = (CNT_W'(i) >= count_reg);

        if (i == 0)
        begin : g_head
            assign prev_value   = '0;
            assign prev_greater = 1'b0;
        end
        else
        begin : g_body
            assign prev_value   = cell_value[i-1];
            assign prev_greater = cell_greater[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_value = '0;
        end
        else
        begin : g_link
            assign next_value = cell_value[i+1];
        end

        mhpq_cell u_cell (
            .clk          (clk),
            .ctl          (ctl),
            .vacant       (vacant),
            .prev_value   (prev_value),
            .prev_greater (prev_greater),
            .next_value   (next_value),
            .value        (cell_value[i]),
            .greater      (cell_greater[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (insert_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (remove_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp_next               = rsp_reg;
        rsp_next.status        = STATUS_OK;
        rsp_next.removed_value = '0;
        rsp_next.entry_total   = TOTAL_W'(count_next);
        rsp_next.top_value     = '0;
        if (req.req_type == REQ_INSERT)
        begin
            if (is_full)
            begin
                rsp_next.status    = STATUS_FULL;
                rsp_next.top_value = cell_value[0];
            end
            else if (cell_greater[0])
            begin
                rsp_next.top_value = req.value;
            end
            else
            begin
                rsp_next.top_value = cell_value[0];
            end
        end
        else
        begin
            if (is_empty)
            begin
                rsp_next.status = STATUS_EMPTY;
            end
            else
            begin
                rsp_next.removed_value = cell_value[0];
                if (count_reg > CNT_W'(1))
                begin
                    rsp_next.top_value = cell_value[1];
                end
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The count never runs past the number of cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // Every request transfer yields a pending response on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("request transfer without a response");

    // The chain stays in descending order at its head.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg > CNT_W'(1)) |-> !(cell_value[1] > cell_value[0]))
        else $error("cell chain out of order");

    // A pending response reports the count that the queue now holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.entry_total == TOTAL_W'(count_reg)))
        else $error("response count disagrees with queue");

    // A full flag is only given while the queue is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status == STATUS_FULL))
            |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("full status on a queue that is not full");

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the max-heap priority queue with a heap scoreboard.
module testbench;
    import mhpq_pkg::*;

    localparam int CAPACITY    = DEFAULT_CAPACITY;
    localparam int RANDOM_OPS  = 2000;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    // Keeps its own binary heap and the queue of responses still owed by the block.
    class heap_scoreboard;
        logic signed [VALUE_W-1:0] store [1:CAPACITY];
        int unsigned               held;
        rsp_t                      owed_q[$];
        int                        failures;

        function new();
            held     = 0;
            failures = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void note_request(req_t r);
            rsp_t                      e;
            int unsigned               pos;
            int unsigned               kid;
            logic signed [VALUE_W-1:0] t;
            e = '0;
            e.status = STATUS_OK;
            if (r.req_type == REQ_INSERT) begin
                if (held >= CAPACITY) begin
                    e.status = STATUS_FULL;
                end
                else begin
                    held++;
                    store[held] = r.value;
                    pos = held;
                    while (pos > 1 && store[pos] > store[pos / 2]) begin
                        t               = store[pos];
                        store[pos]      = store[pos / 2];
                        store[pos / 2]  = t;
                        pos             = pos / 2;
                    end
                end
            end
            else begin
                if (held == 0) begin
                    e.status = STATUS_EMPTY;
                end
                else begin
                    e.removed_value = store[1];
                    store[1] = store[held];
                    held--;
                    pos = 1;
                    // The larger child wins; the left one wins a tie.
                    while (2 * pos <= held) begin
                        kid = 2 * pos;
                        if (kid + 1 <= held && store[kid + 1] > store[kid])
                            kid++;
                        if (!(store[kid] > store[pos]))
                            break;
                        t          = store[kid];
                        store[kid] = store[pos];
                        store[pos] = t;
                        pos        = kid;
                    end
                end
            end
            e.entry_total = held[TOTAL_W-1:0];
            e.top_value   = (held > 0) ? store[1] : '0;
            owed_q.push_back(e);
        endfunction

        function void check_response(rsp_t r);
            rsp_t e;
            if (owed_q.size() == 0) begin
                $error("unexpected response: status %0d removed %0d total %0d top %0d",
                       r.status, r.removed_value, r.entry_total, r.top_value);
                failures++;
                return;
            end
            e = owed_q.pop_front();
            if (r.status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, r.status);
                failures++;
            end
            if (r.removed_value !== e.removed_value) begin
                $error("removed_value: expected %0d, actual %0d",
                       e.removed_value, r.removed_value);
                failures++;
            end
            if (r.entry_total !== e.entry_total) begin
                $error("entry_total: expected %0d, actual %0d", e.entry_total, r.entry_total);
                failures++;
            end
            if (r.top_value !== e.top_value) begin
                $error("top_value: expected %0d, actual %0d", e.top_value, r.top_value);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    heap_scoreboard sb;
    int unsigned    cycles = 0;

    max_heap_priority_queue #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Both transfers are observed at the rising edge; the request is noted first.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
        end
    end

    // The receiver switches between stall patterns of random length.
    int unsigned stall_mode = 0;
    int unsigned mode_left  = 0;
    int unsigned phase      = 0;

    always @(negedge clk)
    begin
        logic next_stall;
        next_stall = 1'b0;
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 4);
            mode_left  <= $urandom_range(20, 200);
        end
        else begin
            mode_left <= mode_left - 1;
            case (stall_mode)
                0: next_stall = 1'b0;
                1: next_stall = ($urandom_range(0, 3) == 0);
                2: next_stall = ($urandom_range(0, 3) != 0);
                3: next_stall = (phase % 4 != 0);
                default: next_stall = (phase % 16 < 12);
            endcase
        end
        phase     <= phase + 1;
        rsp_stall <= next_stall;
    end

    task automatic send_request(input req_kind_t kind, input logic signed [VALUE_W-1:0] v);
        @(negedge clk);
        req_valid    <= 1'b1;
        req.req_type <= kind;
        req.value    <= v;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic pause_sender(input int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $signed($urandom_range(0, 8)) - 4;
            7:          return VALUE_MAX;
            8:          return VALUE_MIN;
            default:    return $urandom_range(0, 1) ? '0 : -1;
        endcase
    endfunction

    initial
    begin
        int unsigned sent;
        int unsigned seg_left;
        int unsigned insert_pct;
        int unsigned burst_left;
        sb        = new();
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty remove, extremes, ties and a full drain.
        send_request(REQ_REMOVE, VALUE_MAX);
        send_request(REQ_INSERT, 0);
        send_request(REQ_INSERT, VALUE_MAX);
        send_request(REQ_INSERT, VALUE_MIN);
        send_request(REQ_INSERT, -1);
        send_request(REQ_INSERT, 1);
        send_request(REQ_INSERT, 5);
        send_request(REQ_INSERT, 5);
        send_request(REQ_INSERT, 5);
        repeat (8) send_request(REQ_REMOVE, 0);
        send_request(REQ_REMOVE, -1);
        send_request(REQ_INSERT, VALUE_MIN);
        send_request(REQ_INSERT, VALUE_MIN);
        repeat (3) send_request(REQ_REMOVE, VALUE_MIN);

        // Random segments with an insert bias of their own; the first one fills the heap.
        sent       = 0;
        seg_left   = 250;
        insert_pct = 95;
        burst_left = $urandom_range(1, 40);
        while (sent < RANDOM_OPS) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(50, 300);
                case ($urandom_range(0, 3))
                    0:       insert_pct = 95;
                    1:       insert_pct = 65;
                    2:       insert_pct = 50;
                    default: insert_pct = 15;
                endcase
            end
            if (burst_left == 0) begin
                pause_sender($urandom_range(1, 8));
                burst_left = $urandom_range(1, 40);
            end
            if ($urandom_range(0, 99) < insert_pct)
                send_request(REQ_INSERT, pick_value());
            else
                send_request(REQ_REMOVE, pick_value());
            sent++;
            seg_left--;
            burst_left--;
        end
        pause_sender(1);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            sb.failures++;
        if (sb.failures == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

### sim.f
design/mhpq_pkg.sv
design/mhpq_cell.sv
design/max_heap_priority_queue.sv
verif/testbench.sv
